// ----- rtl/sha256_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [2:0] LAST_WORD = 3'd7;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic load_word;   // shift an assembled message word into the schedule
        logic init_work;   // copy the chaining words into a..h
        logic round;       // run one compression round
        logic fold;        // add a..h into the chaining words
        logic rotate;      // advance the chaining words toward the output
        logic load_iv;     // restore the initial hash values
    } t_core_ctl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_FOLD = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/sha256_round.sv -----
// One SHA-256 round and one message schedule step, shared by all 64 rounds.
module sha256_round import sha256_pkg::*; (
    input  t_word [7:0]  i_work,    // a..h, a at index 0
    input  t_word [15:0] i_sched,   // rolling schedule, oldest word at index 0
    input  t_word        i_k,
    output t_word [7:0]  o_work,
    output t_word        o_wnew
);

    t_word w_sum1;
    t_word w_sum2;
    t_word w_ch;
    t_word w_maj;

    always_comb begin
        w_ch   = (i_work[4] & i_work[5]) ^ (~i_work[4] & i_work[6]);
        w_maj  = (i_work[0] & i_work[1]) ^ (i_work[0] & i_work[2]) ^ (i_work[1] & i_work[2]);
        w_sum1 = i_work[7] + big_sig1(i_work[4]) + w_ch + i_k + i_sched[0];
        w_sum2 = big_sig0(i_work[0]) + w_maj;

        o_work[0] = w_sum1 + w_sum2;
        o_work[1] = i_work[0];
        o_work[2] = i_work[1];
        o_work[3] = i_work[2];
        o_work[4] = i_work[3] + w_sum1;
        o_work[5] = i_work[4];
        o_work[6] = i_work[5];
        o_work[7] = i_work[6];

        // Word sixteen places ahead of the one consumed this round.
        o_wnew = small_sig1(i_sched[14]) + i_sched[9] + small_sig0(i_sched[1]) + i_sched[0];
    end

endmodule

// ----- rtl/sha256_core.sv -----
// Compression datapath: chaining words, working words, message schedule.
module sha256_core import sha256_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_word     i_word,
    input  logic [5:0] i_round,
    output t_word     o_chain0
);

    t_word [7:0]  r_chain;
    t_word [7:0]  r_work;
    t_word [15:0] r_sched;
    t_word [7:0]  n_chain;
    t_word [7:0]  w_work_nx;
    t_word        w_wnew;

    sha256_round u_round (
        .i_work  (r_work),
        .i_sched (r_sched),
        .i_k     (round_k(i_round)),
        .o_work  (w_work_nx),
        .o_wnew  (w_wnew)
    );

    always_comb begin
        n_chain = r_chain;
        priority if (i_ctl.load_iv) begin
            for (int i = 0; i < 8; i++) n_chain[i] = init_hash(3'(i));
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) n_chain[i] = r_chain[i] + r_work[i];
        end else if (i_ctl.rotate) begin
            for (int i = 0; i < 7; i++) n_chain[i] = r_chain[i + 1];
            n_chain[7] = r_chain[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
        end else begin
            r_chain <= n_chain;
        end
    end

    // Schedule doubles as the block buffer: message words shift in, rounds shift them out.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_word) begin
            r_sched <= {i_word, r_sched[15:1]};
        end else if (i_ctl.round) begin
            r_sched <= {w_wnew, r_sched[15:1]};
        end
        if (i_ctl.init_work) begin
            r_work <= r_chain;
        end else if (i_ctl.round) begin
            r_work <= w_work_nx;
        end
    end

    assign o_chain0 = r_chain[0];

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// Top level: byte intake, padding sequencer and digest output of the SHA-256 hasher.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: data_byte, tuser: byte_valid,
//                                              tlast: message_end
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: digest_word, tuser: word_index,
//                                              tlast: final_word
//
//  A message byte is taken while idle; the 64th byte of a block starts the rounds on
//  the single round unit, then a fold into the chaining words. An end beat feeds
//  padding bytes one per cycle up to the block end, runs one or two compressions,
//  then shows eight digest beats.
//  Reset (synchronous, active low) restores the initial hash values and empties the buffer.
//  Input is not taken while compressing, padding or showing the digest; the digest
//  beats hold while m_axis_tready is low.
module sha256_stream_hasher import sha256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // final_word
);

    t_state      r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [23:0] r_acc, n_acc;
    logic [60:0] r_cnt, n_cnt;      // message length in bytes; bit length is r_cnt * 8
    logic [5:0]  r_round, n_round;
    logic        r_pad, n_pad;      // message closed, padding under way
    logic        r_mark, n_mark;    // 0x80 already placed
    logic        r_lenblk, n_lenblk;// current block carries the length
    logic        r_final, n_final;  // block being compressed is the last one
    logic [2:0]  r_oidx, n_oidx;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_push;
    logic [7:0]  w_byte;
    logic [7:0]  w_len_byte;
    logic        w_block_done;
    t_core_ctl   w_ctl;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == LAST_WORD);

    // Big-endian length byte for positions 56..63.
    assign w_len_byte = 8'({r_cnt, 3'b000} >> {~r_pos[2:0], 3'b000});

    always_comb begin
        w_push = 1'b0;
        w_byte = s_axis_tdata;
        unique case (r_state)
            S_IDLE: w_push = w_in_acc && s_axis_tuser;
            S_PAD: begin
                w_push = 1'b1;
                priority if (!r_mark) begin
                    w_byte = PAD_BYTE;
                end else if (r_lenblk && r_pos >= LEN_POS) begin
                    w_byte = w_len_byte;
                end else begin
                    w_byte = 8'h00;
                end
            end
            S_COMP, S_FOLD, S_OUT: w_push = 1'b0;
            default: w_push = 1'b0;
        endcase
    end

    assign w_block_done = w_push && (r_pos == LAST_POS);

    always_comb begin
        w_ctl.load_word = w_push && (r_pos[1:0] == 2'b11);
        w_ctl.init_work = w_block_done;
        w_ctl.round     = (r_state == S_COMP);
        w_ctl.fold      = (r_state == S_FOLD);
        w_ctl.rotate    = w_out_acc;
        w_ctl.load_iv   = w_out_acc && (r_oidx == LAST_WORD);
    end

    sha256_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_word   ({r_acc, w_byte}),
        .i_round  (r_round),
        .o_chain0 (m_axis_tdata)
    );

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_round  = r_round;
        n_pad    = r_pad;
        n_mark   = r_mark;
        n_lenblk = r_lenblk;
        n_final  = r_final;
        n_oidx   = r_oidx;

        if (w_push) begin
            n_pos = r_pos + 6'd1;
            n_acc = {r_acc[15:0], w_byte};
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser) n_cnt = r_cnt + 61'd1;
                    if (s_axis_tlast) begin
                        n_pad   = 1'b1;
                        n_mark  = 1'b0;
                        n_final = 1'b0;
                    end
                    priority if (w_block_done) begin
                        n_state = S_COMP;
                        n_round = '0;
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (!r_mark) begin
                    n_mark   = 1'b1;
                    n_lenblk = (r_pos < LEN_POS);
                end
                if (w_block_done) begin
                    n_state  = S_COMP;
                    n_round  = '0;
                    n_final  = r_mark && r_lenblk;
                    n_lenblk = 1'b1;
                end
            end
            S_COMP: begin
                n_round = r_round + 6'd1;
                if (r_round == LAST_RND) n_state = S_FOLD;
            end
            S_FOLD: begin
                priority if (r_final) begin
                    n_state = S_OUT;
                    n_oidx  = '0;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == LAST_WORD) begin
                        n_state  = S_IDLE;
                        n_cnt    = '0;
                        n_pad    = 1'b0;
                        n_mark   = 1'b0;
                        n_final  = 1'b0;
                        n_lenblk = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_round  <= '0;
            r_pad    <= 1'b0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_final  <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_round  <= n_round;
            r_pad    <= n_pad;
            r_mark   <= n_mark;
            r_lenblk <= n_lenblk;
            r_final  <= n_final;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while digest is shown");

    a_comp_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_pos == 6'd0))
        else $error("compression started on a partial block");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_round == LAST_RND) |=> (r_state == S_FOLD))
        else $error("compression did not end after the last round");

    a_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_pos == 6'd0 && r_pad))
        else $error("digest shown with bytes left in the buffer");

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && m_axis_tlast) |=> (s_axis_tready && r_cnt == 61'd0))
        else $error("hasher not ready for a new message after the digest");
`endif

endmodule
